>>> rtl/core/shk_pkg.sv
// Shared types, codes and frame constants for the SET/UA link handshake.
package shk_pkg;

	// Frame bytes
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] SET_ADDR  = 8'h03;
	localparam logic [7:0] SET_CTRL  = 8'h03;
	localparam logic [7:0] UA_ADDR   = 8'h01;
	localparam logic [7:0] UA_CTRL   = 8'h07;

	// Frame geometry
	localparam int unsigned        FRAME_LEN = 5;
	localparam logic [2:0]         LAST_IDX  = 3'(FRAME_LEN - 1);

	// Register indexes
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_LIMIT   = 1'b1;

	// Reset values of the registers
	localparam logic [15:0] TIMEOUT_RST = 16'd3;
	localparam logic [3:0]  LIMIT_RST   = 4'd3;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Input operations
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Link status codes as reported
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_WAIT = 2'd1,
		ST_CONN = 2'd2,
		ST_FAIL = 2'd3
	} status_t;

	// Link phase state machine
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_WAIT = 4'b0010,
		PH_CONN = 4'b0100,
		PH_FAIL = 4'b1000
	} phase_t;

	// One queued command: send a SET frame or report status only
	typedef struct packed {
		logic    send_set;
		status_t status;
	} cmd_t;

	// Byte k of the SET frame
	function automatic logic [7:0] set_byte(input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = FLAG_BYTE;
			3'd1: b = SET_ADDR;
			3'd2: b = SET_CTRL;
			3'd3: b = SET_ADDR ^ SET_CTRL;
			3'd4: b = FLAG_BYTE;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Byte k of the UA frame
	function automatic logic [7:0] ua_byte(input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = FLAG_BYTE;
			3'd1: b = UA_ADDR;
			3'd2: b = UA_CTRL;
			3'd3: b = UA_ADDR ^ UA_CTRL;
			3'd4: b = FLAG_BYTE;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Encode phase into reported status
	function automatic status_t phase_status(input phase_t ph);
		status_t s;
		case (ph)
			PH_IDLE: s = ST_IDLE;
			PH_WAIT: s = ST_WAIT;
			PH_CONN: s = ST_CONN;
			PH_FAIL: s = ST_FAIL;
			default: s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/shk_front.sv
// Front part: takes input beats, runs matcher, timer and retry logic, queues commands.
module shk_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [1:0]       opcode,
	input  logic [7:0]       rx_byte,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [15:0]      cfg_wdata,
	input  logic             q_full,
	output logic             q_push,
	output shk_pkg::cmd_t    q_cmd
);

	logic [15:0]      timeout_q;
	logic [3:0]       limit_q;
	logic [2:0]       step_q, step_n;
	logic [15:0]      tick_q, tick_n;
	logic [3:0]       retry_q, retry_n;
	shk_pkg::phase_t  phase_q, phase_n;
	logic             send_n;
	logic [7:0]       exp_byte, prev_byte;
	logic [16:0]      tick_inc;
	logic [3:0]       retry_inc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= shk_pkg::TIMEOUT_RST;
			limit_q   <= shk_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				shk_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata;
				shk_pkg::REG_LIMIT:   limit_q   <= cfg_wdata[3:0];
				default:              timeout_q <= timeout_q;
			endcase
		end
	end

	assign q_push    = push & ~q_full;
	assign exp_byte  = shk_pkg::ua_byte(step_q);
	assign prev_byte = shk_pkg::ua_byte(step_q - 3'd1);
	assign tick_inc  = {1'b0, tick_q} + 17'd1;
	assign retry_inc = retry_q + 4'd1;

	// Classify the beat and work out the next link state
	always_comb begin
		step_n  = step_q;
		tick_n  = tick_q;
		retry_n = retry_q;
		phase_n = phase_q;
		send_n  = 1'b0;
		case (shk_pkg::op_t'(opcode))
			shk_pkg::OP_START: begin
				step_n  = 3'd0;
				tick_n  = 16'd0;
				retry_n = 4'd0;
				phase_n = shk_pkg::PH_WAIT;
				send_n  = 1'b1;
			end
			shk_pkg::OP_BYTE: begin
				if (phase_q == shk_pkg::PH_WAIT) begin
					if (rx_byte == exp_byte) begin
						if (step_q == shk_pkg::LAST_IDX) begin
							step_n  = 3'd0;
							tick_n  = 16'd0;
							phase_n = shk_pkg::PH_CONN;
						end else begin
							step_n = step_q + 3'd1;
						end
					end else if (step_q != 3'd0 && rx_byte == prev_byte) begin
						step_n = step_q;
					end else begin
						step_n = 3'd0;
					end
				end
			end
			shk_pkg::OP_TICK: begin
				if (phase_q == shk_pkg::PH_WAIT) begin
					if (tick_inc >= {1'b0, timeout_q}) begin
						tick_n  = 16'd0;
						retry_n = retry_inc;
						send_n  = 1'b1;
						if (retry_inc >= limit_q) begin
							phase_n = shk_pkg::PH_FAIL;
						end
					end else begin
						tick_n = tick_inc[15:0];
					end
				end
			end
			default: send_n = 1'b0;
		endcase
	end

	// Advance link state on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 3'd0;
			tick_q  <= 16'd0;
			retry_q <= 4'd0;
			phase_q <= shk_pkg::PH_IDLE;
		end else if (q_push) begin
			step_q  <= step_n;
			tick_q  <= tick_n;
			retry_q <= retry_n;
			phase_q <= phase_n;
		end
	end

	assign q_cmd.send_set = send_n;
	assign q_cmd.status   = shk_pkg::phase_status(phase_n);

endmodule

>>> rtl/core/shk_queue.sv
// Small command queue between the front and back parts.
module shk_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  shk_pkg::cmd_t wr_cmd,
	input  logic          rd_en,
	output shk_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          nonempty
);

	shk_pkg::cmd_t                   mem [shk_pkg::QUEUE_DEPTH];
	logic [shk_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [shk_pkg::QCNT_W-1:0]      count_q;

	assign full     = (count_q == shk_pkg::QCNT_W'(shk_pkg::QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_cmd   = mem[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + shk_pkg::QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + shk_pkg::QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + shk_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - shk_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/shk_back.sv
// Back part: expands queued commands into result beats, one per cycle while pop is high.
module shk_back (
	input  logic          clk,
	input  logic          arst_n,
	input  shk_pkg::cmd_t q_cmd,
	input  logic          q_nonempty,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    tx_byte,
	output logic          tx_valid,
	output logic          last,
	output logic [1:0]    link_status
);

	logic          valid_q;
	shk_pkg::cmd_t cmd_q;
	logic [2:0]    idx_q;
	logic          last_w;
	logic          load;

	assign last_w = ~cmd_q.send_set | (idx_q == shk_pkg::LAST_IDX);
	assign load   = ~valid_q | (pop & last_w);
	assign q_pop  = load & q_nonempty;

	// Hold the current command and step through its frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= q_nonempty;
			idx_q   <= 3'd0;
		end else if (pop) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_cmd;
		end
	end

	assign empty       = ~valid_q;
	assign tx_valid    = cmd_q.send_set;
	assign tx_byte     = cmd_q.send_set ? shk_pkg::set_byte(idx_q) : 8'h00;
	assign last        = last_w;
	assign link_status = cmd_q.status;

endmodule

>>> rtl/core/set_ua_link_handshake.sv
// Top level of the SET/UA link handshake, sender side.
// An accepted beat waits in the four-entry queue, then in the back command register.
// Throughput: one input beat per cycle unless full; a start or timeout yields a
// five-beat SET frame, so the result side drains one beat per cycle while pop is high.
// Reset (arst_n low): link idle, counters cleared, queue and output empty,
// timeout and retry limit registers back to 3.
module set_ua_link_handshake (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  tx_byte,
	output logic        tx_valid,
	output logic        last,
	output logic [1:0]  link_status,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata
);

	shk_pkg::cmd_t fr_cmd, bk_cmd;
	logic          fr_push, bk_pop, q_nonempty;

	shk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.opcode    (opcode),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_full    (full),
		.q_push    (fr_push),
		.q_cmd     (fr_cmd)
	);

	shk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fr_push),
		.wr_cmd   (fr_cmd),
		.rd_en    (bk_pop),
		.rd_cmd   (bk_cmd),
		.full     (full),
		.nonempty (q_nonempty)
	);

	shk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_cmd       (bk_cmd),
		.q_nonempty  (q_nonempty),
		.q_pop       (bk_pop),
		.pop         (pop),
		.empty       (empty),
		.tx_byte     (tx_byte),
		.tx_valid    (tx_valid),
		.last        (last),
		.link_status (link_status)
	);

endmodule

>>> rtl/core/shk_checker.sv
// Port-level checks for the SET/UA link handshake, bound to the top level.
module shk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] tx_byte,
	input logic       tx_valid,
	input logic       last,
	input logic [1:0] link_status
);

	// A status-only beat carries no byte and closes its item
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !tx_valid) |-> (tx_byte == 8'h00 && last))
		else $error("status beat carries a byte or is not last");

	// A frame beat is never sent while the link is idle
	a_send_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && tx_valid) |-> (link_status != shk_pkg::ST_IDLE))
		else $error("frame beat reported with idle link");

	// A frame continues without a gap once started
	a_frame_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && tx_valid && !last && pop) |=> (!empty && tx_valid))
		else $error("frame beat missing inside a SET frame");

	// A frame's last beat is the flag byte
	a_flag_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && tx_valid && last) |-> (tx_byte == shk_pkg::FLAG_BYTE))
		else $error("frame does not end on a flag");

	// A waiting beat holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(last)))
		else $error("waiting result beat changed");

endmodule

bind set_ua_link_handshake shk_checker u_shk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.tx_byte     (tx_byte),
	.tx_valid    (tx_valid),
	.last        (last),
	.link_status (link_status)
);

>>> bench/tb_top.sv
// Self-checking testbench for the SET/UA link handshake, sender side.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_WAIT       = 20;
	localparam int MAX_REPORTS    = 10;

	localparam logic [7:0] SET_SEQ [5] = '{shk_pkg::FLAG_BYTE, shk_pkg::SET_ADDR,
		shk_pkg::SET_CTRL, shk_pkg::SET_ADDR ^ shk_pkg::SET_CTRL, shk_pkg::FLAG_BYTE};
	localparam logic [7:0] UA_SEQ [5] = '{shk_pkg::FLAG_BYTE, shk_pkg::UA_ADDR,
		shk_pkg::UA_CTRL, shk_pkg::UA_ADDR ^ shk_pkg::UA_CTRL, shk_pkg::FLAG_BYTE};

	typedef struct packed {
		shk_pkg::op_t op;
		logic [7:0]   data;
	} line_item_t;

	typedef struct packed {
		logic [7:0]       txb;
		logic             valid;
		logic             fin;
		shk_pkg::status_t status;
	} tx_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  opcode = shk_pkg::OP_NONE;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  tx_byte;
	logic        tx_valid;
	logic        last;
	logic [1:0]  link_status;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = shk_pkg::REG_TIMEOUT;
	logic [15:0] cfg_wdata = 16'h0000;

	// Handshake mirror: registers and link state as the block should hold them
	logic [15:0]      timeout_cfg = shk_pkg::TIMEOUT_RST;
	logic [3:0]       limit_cfg = shk_pkg::LIMIT_RST;
	int               ua_pos = 0;
	logic [15:0]      tick_run = 16'd0;
	logic [3:0]       resend_count = 4'd0;
	shk_pkg::status_t link_now = shk_pkg::ST_IDLE;

	line_item_t  pending_items[$];
	tx_beat_t    expected_beats[$];
	int          mismatches = 0;
	int          send_wait = 0;
	int          send_calm = 0;
	int          recv_wait = 0;
	int          recv_calm = 0;
	int          idle_cycles = 0;

	set_ua_link_handshake uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.tx_byte    (tx_byte),
		.tx_valid   (tx_valid),
		.last       (last),
		.link_status(link_status),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	// Clock: 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Draw a per-beat wait; now and then run a calm stretch with no waits
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic void add_item(shk_pkg::op_t op, logic [7:0] data);
		line_item_t it;
		it.op = op;
		it.data = data;
		pending_items.push_back(it);
	endfunction

	function automatic void emit_status_beat();
		tx_beat_t b;
		b.txb = 8'h00;
		b.valid = 1'b0;
		b.fin = 1'b1;
		b.status = link_now;
		expected_beats.push_back(b);
	endfunction

	function automatic void emit_set_frame();
		tx_beat_t b;
		for (int k = 0; k < 5; k++) begin
			b.txb = SET_SEQ[k];
			b.valid = 1'b1;
			b.fin = (k == 4);
			b.status = link_now;
			expected_beats.push_back(b);
		end
	endfunction

	// Advance the mirror by one accepted beat and queue the beats it yields
	function automatic void handshake_predict(shk_pkg::op_t op, logic [7:0] data);
		int s;
		int t;
		case (op)
			shk_pkg::OP_START: begin
				ua_pos = 0;
				tick_run = 16'd0;
				resend_count = 4'd0;
				link_now = shk_pkg::ST_WAIT;
				emit_set_frame();
			end
			shk_pkg::OP_BYTE: begin
				if (link_now == shk_pkg::ST_WAIT) begin
					s = (ua_pos > 4) ? 0 : ua_pos;
					if (data == UA_SEQ[s])
						s++;
					else if (!(s > 0 && data == UA_SEQ[s - 1]))
						s = 0;
					// full UA frame: stop the timer and connect
					if (s >= 5) begin
						ua_pos = 0;
						tick_run = 16'd0;
						link_now = shk_pkg::ST_CONN;
					end else begin
						ua_pos = s;
					end
				end
				emit_status_beat();
			end
			shk_pkg::OP_TICK: begin
				if (link_now == shk_pkg::ST_WAIT) begin
					t = int'(tick_run) + 1;
					// timeout: resend SET, keep the match step
					if (t >= int'(timeout_cfg)) begin
						tick_run = 16'd0;
						resend_count = resend_count + 4'd1;
						if (resend_count >= limit_cfg)
							link_now = shk_pkg::ST_FAIL;
						emit_set_frame();
					end else begin
						tick_run = 16'(t);
						emit_status_beat();
					end
				end else begin
					emit_status_beat();
				end
			end
			default: emit_status_beat();
		endcase
	endfunction

	// Queue well-formed handshakes with random noise, repeats and ticks mixed in
	task automatic queue_sessions(int n);
		int left;
		int pos;
		int len;
		int r;
		left = n;
		while (left > 0) begin
			add_item(shk_pkg::OP_START, 8'($urandom));
			left--;
			pos = 0;
			len = $urandom_range(4, 20);
			for (int k = 0; k < len && left > 0; k++) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					add_item(shk_pkg::OP_BYTE, UA_SEQ[pos]);
					pos = (pos + 1) % 5;
				end else if (r < 55) begin
					add_item(shk_pkg::OP_BYTE, UA_SEQ[(pos == 0) ? 0 : pos - 1]);
				end else if (r < 76) begin
					add_item(shk_pkg::OP_TICK, 8'($urandom));
				end else if (r < 89) begin
					add_item(shk_pkg::OP_BYTE, 8'($urandom));
					pos = 0;
				end else if (r < 95) begin
					add_item(shk_pkg::OP_NONE, 8'($urandom));
				end else begin
					add_item(shk_pkg::OP_START, 8'($urandom));
					pos = 0;
				end
				left--;
			end
		end
	endtask

	// Wait until every beat is sent and every expected result has come back
	task automatic settle();
		while (pending_items.size() != 0 || push || expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == shk_pkg::REG_TIMEOUT)
			timeout_cfg = val;
		else
			limit_cfg = val[3:0];
	endtask

	// Driver: present pending beats, predict each one as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				handshake_predict(shk_pkg::op_t'(opcode), rx_byte);
			if (push && full) begin
				// hold the beat until it is taken
			end else if (send_wait > 0) begin
				send_wait--;
				push <= 1'b0;
			end else if (pending_items.size() != 0) begin
				push <= 1'b1;
				opcode <= pending_items[0].op;
				rx_byte <= pending_items[0].data;
				void'(pending_items.pop_front());
				send_wait = draw_gap(send_calm);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: pop results with random stalls and check each against the oldest beat
	always @(posedge clk) begin
		tx_beat_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: result with nothing expected: byte %h",
							" valid %b last %b st %0d"},
							$realtime, tx_byte, tx_valid, last, link_status);
				end else begin
					want = expected_beats.pop_front();
					if (tx_byte !== want.txb || tx_valid !== want.valid ||
							last !== want.fin || link_status !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"%0t: mismatch: byte %h/%h valid %b/%b last %b/%b",
								" st %0d/%0d (exp/act)"}, $realtime, want.txb, tx_byte,
								want.valid, tx_valid, want.fin, last, want.status,
								link_status);
					end
				end
				recv_wait = draw_gap(recv_calm);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: end the run after too long with no beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** set_ua_link_handshake: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ignored beats while idle, then a UA with repeated fields
		add_item(shk_pkg::OP_TICK, 8'hFF);
		add_item(shk_pkg::OP_BYTE, shk_pkg::FLAG_BYTE);
		add_item(shk_pkg::OP_NONE, 8'h00);
		add_item(shk_pkg::OP_START, 8'h00);
		add_item(shk_pkg::OP_BYTE, shk_pkg::FLAG_BYTE);
		add_item(shk_pkg::OP_BYTE, shk_pkg::FLAG_BYTE);
		add_item(shk_pkg::OP_BYTE, shk_pkg::UA_ADDR);
		add_item(shk_pkg::OP_BYTE, shk_pkg::UA_ADDR);
		add_item(shk_pkg::OP_BYTE, shk_pkg::UA_CTRL);
		add_item(shk_pkg::OP_BYTE, shk_pkg::UA_ADDR ^ shk_pkg::UA_CTRL);
		add_item(shk_pkg::OP_BYTE, shk_pkg::FLAG_BYTE);
		add_item(shk_pkg::OP_TICK, 8'h00);
		// Restart from connected, break the match, then time out until failed
		add_item(shk_pkg::OP_START, 8'hFF);
		add_item(shk_pkg::OP_BYTE, shk_pkg::FLAG_BYTE);
		add_item(shk_pkg::OP_BYTE, shk_pkg::UA_ADDR);
		add_item(shk_pkg::OP_BYTE, 8'h55);
		repeat (9) add_item(shk_pkg::OP_TICK, 8'hAA);
		add_item(shk_pkg::OP_TICK, 8'h00);
		add_item(shk_pkg::OP_BYTE, 8'hFF);
		add_item(shk_pkg::OP_START, 8'h00);
		queue_sessions(70);
		settle();

		// Shortest timeout and limit: every tick resends and fails at once
		write_reg(shk_pkg::REG_TIMEOUT, 16'd1);
		write_reg(shk_pkg::REG_LIMIT, 16'd1);
		queue_sessions(50);
		settle();

		// Longest timeout and limit
		write_reg(shk_pkg::REG_TIMEOUT, 16'hFFFF);
		write_reg(shk_pkg::REG_LIMIT, 16'd15);
		queue_sessions(80);
		settle();

		write_reg(shk_pkg::REG_TIMEOUT, 16'd2);
		write_reg(shk_pkg::REG_LIMIT, 16'd15);
		queue_sessions(70);
		settle();

		write_reg(shk_pkg::REG_LIMIT, 16'($urandom_range(1, 15)));
		write_reg(shk_pkg::REG_TIMEOUT, 16'($urandom_range(1, 8)));
		queue_sessions(60);
		settle();

		repeat (END_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("** set_ua_link_handshake: PASSED **");
		else
			$display("** set_ua_link_handshake: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/shk_pkg.sv
rtl/core/shk_front.sv
rtl/core/shk_queue.sv
rtl/core/shk_back.sv
rtl/core/set_ua_link_handshake.sv
rtl/core/shk_checker.sv
bench/tb_top.sv
